@@ src/assert_macros.svh @@
// Assertion helpers shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CHK_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define CHK_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

@@ src/skcc_pkg.sv @@
package skcc_pkg;

  // Datapath operation codes issued by the controller.
  localparam logic [4:0] OP_NONE   = 5'd0;
  localparam logic [4:0] OP_LOAD   = 5'd1;
  localparam logic [4:0] OP_READ   = 5'd2;
  localparam logic [4:0] OP_SETPAR = 5'd3;
  localparam logic [4:0] OP_CLRENV = 5'd4;
  localparam logic [4:0] OP_FETCH  = 5'd5;
  localparam logic [4:0] OP_ENV_A  = 5'd6;
  localparam logic [4:0] OP_ENV_B  = 5'd7;
  localparam logic [4:0] OP_ENV_W  = 5'd8;
  localparam logic [4:0] OP_NORM   = 5'd9;
  localparam logic [4:0] OP_SQR    = 5'd10;
  localparam logic [4:0] OP_DB_A   = 5'd11;
  localparam logic [4:0] OP_DB_B   = 5'd12;
  localparam logic [4:0] OP_LVL    = 5'd13;
  localparam logic [4:0] OP_CV_A   = 5'd14;
  localparam logic [4:0] OP_CV_B   = 5'd15;
  localparam logic [4:0] OP_CV_C   = 5'd16;
  localparam logic [4:0] OP_CV_D   = 5'd17;
  localparam logic [4:0] OP_DIV    = 5'd18;
  localparam logic [4:0] OP_EXP_A  = 5'd19;
  localparam logic [4:0] OP_EXP_B  = 5'd20;
  localparam logic [4:0] OP_EXP_C  = 5'd21;
  localparam logic [4:0] OP_ROOT   = 5'd22;
  localparam logic [4:0] OP_GAIN   = 5'd23;
  localparam logic [4:0] OP_SCALE  = 5'd24;
  localparam logic [4:0] OP_OUT    = 5'd25;

  // Item actions.
  localparam logic [1:0] ACT_SAMPLE = 2'd0;
  localparam logic [1:0] ACT_SETPAR = 2'd1;
  localparam logic [1:0] ACT_CLRENV = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] CFG_ATTACK  = 2'd0;
  localparam logic [1:0] CFG_RELEASE = 2'd1;
  localparam logic [1:0] CFG_KNEE    = 2'd2;

  // Reset values.
  localparam logic [23:0] ATTACK_RESET  = 24'd16739216;
  localparam logic [23:0] RELEASE_RESET = 24'd16774680;
  localparam logic [12:0] KNEE_RESET    = 13'd1536;
  localparam logic [15:0] THR_RESET     = 16'hEE00;
  localparam logic [14:0] RATIO_RESET   = 15'd1024;
  localparam logic [14:0] RATIO_MIN     = 15'd256;

  // Arithmetic constants.
  localparam logic [14:0] GR_MAX      = 15'd24576;
  localparam logic [14:0] LEVEL_FLOOR = 15'd25600;
  localparam logic [17:0] DB_PER_LOG2 = 18'd197283;
  localparam logic [21:0] LOG2_PER_DB = 22'd2786635;

  // Divider and loop sizes.
  localparam int NUM_W     = 46;
  localparam int DEN_W     = 31;
  localparam int DIV_STEPS = NUM_W;
  localparam int ROOT_STEPS = 16;
  localparam int SQR_STEPS  = 16;

  typedef struct packed {
    logic [4:0] op;
    logic [5:0] step;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic       norm_done;
  } stat_t;

  typedef logic [15:0][30:0] root_tab_t;

  function automatic logic [63:0] isqrt64(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    x = v;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // Q30 roots 2^(-2^-k), k = 1..16, each the floor root of the one before.
  function automatic root_tab_t calc_roots();
    logic [63:0] f;
    root_tab_t   t;
    f = 64'd1 << 29;
    for (int k = 0; k < 16; k++) begin
      f = isqrt64(f << 30);
      t[k] = f[30:0];
    end
    return t;
  endfunction

  localparam root_tab_t ROOT_TAB = calc_roots();

endpackage

@@ src/skcc_ram.sv @@
module skcc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/skcc_datapath.sv @@
`include "assert_macros.svh"

module skcc_datapath import skcc_pkg::*; #(
  parameter int CHANNELS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [23:0]        cfg_data,
  input  logic [1:0]         in_action,
  input  logic [3:0]         in_channel,
  input  logic [15:0]        in_sample,
  input  logic [15:0]        in_threshold,
  input  logic [14:0]        in_ratio,
  input  cmd_t               cmd,
  output stat_t              stat,
  output logic [15:0]        out_sample,
  output logic [16:0]        out_gain,
  output logic [14:0]        out_reduction
);

  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Configuration registers.
  logic [23:0] attack;
  logic [23:0] release_c;
  logic [12:0] knee;

  // Latched item.
  logic [1:0]  it_action;
  logic [3:0]  it_channel;
  logic [15:0] it_sample;
  logic [15:0] it_thr;
  logic [14:0] it_ratio;

  // Channel state and working registers.
  logic [CHANNELS-1:0] env_valid;
  logic [CHANNELS-1:0] par_valid;
  logic        env_vq;
  logic        par_vq;
  logic [31:0] env_rd;
  logic [30:0] par_rd;
  logic [31:0] env;
  logic [15:0] thr;
  logic [14:0] ratio;
  logic [31:0] sq;
  logic [55:0] p1;
  logic [24:0] cc;
  logic [56:0] p2;
  logic [31:0] mreg;
  logic        env_zero;
  logic [4:0]  shcnt;
  logic [15:0] frac;
  logic [21:0] negr;
  logic [39:0] dbp;
  logic signed [17:0] over;
  logic        zero_br;
  logic        hard;
  logic [14:0] x2;
  logic [30:0] prod_a;
  logic [NUM_W-1:0] prod_b;
  logic [DEN_W-1:0] den;
  logic [DEN_W-1:0] rem;
  logic [NUM_W-1:0] dq;
  logic [14:0] gr;
  logic [36:0] ep;
  logic [5:0]  ip;
  logic [15:0] fp;
  logic [30:0] m;
  logic [16:0] gain;
  logic [32:0] sp;

  // Address decode.
  logic [AW+3:0] ch_ext;
  logic [AW-1:0] addr;
  logic          in_range;
  assign ch_ext   = {{AW{1'b0}}, it_channel};
  assign addr     = ch_ext[AW-1:0];
  assign in_range = (ch_ext < (AW+4)'(CHANNELS));

  // Sample magnitude and sign.
  logic [15:0] mag;
  logic        neg;
  assign neg = it_sample[15];
  assign mag = neg ? (16'd0 - it_sample) : it_sample;

  // Square, saturated to 32 bits.
  logic [31:0] msq;
  logic [31:0] sq_sat;
  assign msq    = mag * mag;
  assign sq_sat = msq[30] ? 32'hFFFF_FFFF : {msq[29:0], 2'b00};

  // Envelope pole selection and update sum.
  logic [23:0] csel;
  logic [57:0] env_sum;
  logic [31:0] env_new;
  assign csel    = (sq > env) ? attack : release_c;
  assign env_sum = {2'b00, p1} + {1'b0, p2} + 58'h80_0000;
  assign env_new = env_sum[55:24];

  // Log-domain squaring step.
  logic [63:0] lsq;
  assign lsq = mreg * mreg;

  // dB rounding and floor.
  logic [40:0] db_sum;
  logic [16:0] db_r;
  logic [14:0] lvl;
  logic signed [17:0] lvl_s;
  logic signed [17:0] thr_s;
  assign db_sum = {1'b0, dbp} + 41'h80_0000;
  assign db_r   = db_sum[40:24];
  assign lvl    = (env_zero || (db_r > {2'b00, LEVEL_FLOOR})) ? LEVEL_FLOOR : db_r[14:0];
  assign lvl_s  = {3'b000, lvl};
  assign thr_s  = {{2{thr[15]}}, thr};

  // Knee region decision and first product.
  logic signed [18:0] two;
  logic signed [18:0] ks;
  logic signed [18:0] x2_full;
  logic        hard_c;
  logic [14:0] rm;
  logic [15:0] mul_a;
  assign two     = {over, 1'b0};
  assign ks      = {6'b000000, knee};
  assign x2_full = two + ks;
  assign hard_c  = (two > ks);
  assign rm      = ratio - RATIO_MIN;
  assign mul_a   = hard_c ? over[15:0] : {1'b0, x2_full[14:0]};

  // Second products of the curve.
  logic [45:0] soft_num;
  logic [27:0] rk;
  assign soft_num = prod_a * x2;
  assign rk       = ratio * knee;

  // Restoring divider step.
  logic [DEN_W:0] rem_sh;
  logic           ge;
  assign rem_sh = {rem, dq[NUM_W-1]};
  assign ge     = (rem_sh >= {1'b0, den});

  // Exponent rounding.
  logic [37:0] e_sum;
  assign e_sum = {1'b0, ep} + 38'h8000;

  // Root multiply.
  logic [61:0] rprod;
  logic [62:0] rsum;
  assign rprod = m * ROOT_TAB[cmd.step[3:0]];
  assign rsum  = {1'b0, rprod} + 63'h2000_0000;

  // Final shift to Q1.16.
  logic [55:0] gsum;
  logic [55:0] gshift;
  logic [5:0]  shl;
  logic [5:0]  shr;
  assign shl    = 6'd13 + ip;
  assign shr    = 6'd14 + ip;
  assign gsum   = {25'd0, m} + (56'd1 << shl);
  assign gshift = gsum >> shr;

  // Output rounding.
  logic [33:0] rs;
  logic [15:0] res;
  assign rs  = {1'b0, sp} + 34'h8000;
  assign res = rs[31:16];

  // Storage writes.
  logic        env_we;
  logic [31:0] env_wdata;
  logic        par_we;
  logic [14:0] ratio_cl;
  assign env_we    = in_range && ((cmd.op == OP_ENV_W) || (cmd.op == OP_CLRENV));
  assign env_wdata = (cmd.op == OP_CLRENV) ? 32'd0 : env_new;
  assign par_we    = in_range && (cmd.op == OP_SETPAR);
  assign ratio_cl  = (it_ratio < RATIO_MIN) ? RATIO_MIN : it_ratio;

  skcc_ram #(.WIDTH(32), .DEPTH(CHANNELS)) u_env_ram (
    .clk   (clk),
    .we    (env_we),
    .waddr (addr),
    .wdata (env_wdata),
    .raddr (addr),
    .rdata (env_rd)
  );

  skcc_ram #(.WIDTH(31), .DEPTH(CHANNELS)) u_par_ram (
    .clk   (clk),
    .we    (par_we),
    .waddr (addr),
    .wdata ({ratio_cl, it_thr}),
    .raddr (addr),
    .rdata (par_rd)
  );

  // Configuration registers and per-channel valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      attack    <= ATTACK_RESET;
      release_c <= RELEASE_RESET;
      knee      <= KNEE_RESET;
      env_valid <= '0;
      par_valid <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_ATTACK:  attack    <= cfg_data;
          CFG_RELEASE: release_c <= cfg_data;
          CFG_KNEE:    knee      <= cfg_data[12:0];
          default: ;
        endcase
      end
      if (env_we) begin
        env_valid[addr] <= 1'b1;
      end
      if (par_we) begin
        par_valid[addr] <= 1'b1;
      end
    end
  end

  // Datapath operations.
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        it_action  <= in_action;
        it_channel <= in_channel;
        it_sample  <= in_sample;
        it_thr     <= in_threshold;
        it_ratio   <= in_ratio;
      end
      OP_READ: begin
        env_vq <= in_range && env_valid[addr];
        par_vq <= in_range && par_valid[addr];
      end
      OP_FETCH: begin
        env   <= env_vq ? env_rd : 32'd0;
        thr   <= par_vq ? par_rd[15:0] : THR_RESET;
        ratio <= par_vq ? par_rd[30:16] : RATIO_RESET;
        sq    <= sq_sat;
      end
      OP_ENV_A: begin
        p1 <= env * csel;
        cc <= 25'h100_0000 - {1'b0, csel};
      end
      OP_ENV_B: begin
        p2 <= sq * cc;
      end
      OP_ENV_W: begin
        env      <= env_new;
        mreg     <= env_new;
        env_zero <= (env_new == 32'd0);
        shcnt    <= 5'd0;
        frac     <= 16'd0;
      end
      OP_NORM: begin
        // Coarse then fine leading-zero shift.
        if (!mreg[31] && !env_zero) begin
          if (mreg[31:16] == 16'd0) begin
            mreg  <= {mreg[15:0], 16'd0};
            shcnt <= shcnt + 5'd16;
          end else if (mreg[31:24] == 8'd0) begin
            mreg  <= {mreg[23:0], 8'd0};
            shcnt <= shcnt + 5'd8;
          end else begin
            mreg  <= {mreg[30:0], 1'b0};
            shcnt <= shcnt + 5'd1;
          end
        end
      end
      OP_SQR: begin
        if (lsq[63]) begin
          mreg <= lsq[63:32];
          frac[4'd15 - cmd.step[3:0]] <= 1'b1;
        end else begin
          mreg <= lsq[62:31];
        end
      end
      OP_DB_A: begin
        negr <= {{1'b0, shcnt} + 6'd1, 16'd0} - {6'd0, frac};
      end
      OP_DB_B: begin
        dbp <= negr * DB_PER_LOG2;
      end
      OP_LVL: begin
        over <= -lvl_s - thr_s;
      end
      OP_CV_A: begin
        zero_br <= (two <= -ks) || !in_range;
        hard    <= hard_c;
        x2      <= x2_full[14:0];
        prod_a  <= mul_a * rm;
      end
      OP_CV_B: begin
        prod_b <= hard ? {15'd0, prod_a} : soft_num;
      end
      OP_CV_C: begin
        if (zero_br) begin
          den <= 31'd1;
        end else if (hard) begin
          den <= {16'd0, ratio};
        end else begin
          den <= {rk, 3'b000};
        end
      end
      OP_CV_D: begin
        dq  <= zero_br ? '0 : (prod_b + {15'd0, den[DEN_W-1:1]});
        rem <= '0;
      end
      OP_DIV: begin
        rem <= ge ? rem_sh[DEN_W-1:0] - den : rem_sh[DEN_W-1:0];
        dq  <= {dq[NUM_W-2:0], ge};
      end
      OP_EXP_A: begin
        gr <= (dq > {31'd0, GR_MAX}) ? GR_MAX : dq[14:0];
      end
      OP_EXP_B: begin
        ep <= gr * LOG2_PER_DB;
      end
      OP_EXP_C: begin
        ip <= e_sum[37:32];
        fp <= e_sum[31:16];
        m  <= 31'h4000_0000;
      end
      OP_ROOT: begin
        if (fp[4'd15 - cmd.step[3:0]]) begin
          m <= rsum[60:30];
        end
      end
      OP_GAIN: begin
        gain <= (ip > 6'd40) ? 17'd0 : gshift[16:0];
      end
      OP_SCALE: begin
        sp <= mag * gain;
      end
      OP_OUT: begin
        out_sample    <= neg ? (16'd0 - res) : res;
        out_gain      <= gain;
        out_reduction <= gr;
      end
      default: ;
    endcase
  end

  assign stat.action    = it_action;
  assign stat.norm_done = mreg[31] || env_zero;

  `CHK_NOW(a_sqr_normalized, clk, rst, cmd.op == OP_SQR, mreg[31] || env_zero)
  `CHK_NOW(a_div_den_nonzero, clk, rst, cmd.op == OP_DIV, den != '0)
  `CHK_NEXT(a_gain_unity_max, clk, rst, cmd.op == OP_OUT, out_gain <= 17'd65536)

endmodule

@@ src/skcc_ctrl.sv @@
`include "assert_macros.svh"

module skcc_ctrl import skcc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  output logic  out_valid,
  input  logic  out_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_DISP  = 5'd1;
  localparam logic [4:0] S_FETCH = 5'd2;
  localparam logic [4:0] S_ENVA  = 5'd3;
  localparam logic [4:0] S_ENVB  = 5'd4;
  localparam logic [4:0] S_ENVW  = 5'd5;
  localparam logic [4:0] S_NORM  = 5'd6;
  localparam logic [4:0] S_SQR   = 5'd7;
  localparam logic [4:0] S_DBA   = 5'd8;
  localparam logic [4:0] S_DBB   = 5'd9;
  localparam logic [4:0] S_LVL   = 5'd10;
  localparam logic [4:0] S_CVA   = 5'd11;
  localparam logic [4:0] S_CVB   = 5'd12;
  localparam logic [4:0] S_CVC   = 5'd13;
  localparam logic [4:0] S_CVD   = 5'd14;
  localparam logic [4:0] S_DIV   = 5'd15;
  localparam logic [4:0] S_EXPA  = 5'd16;
  localparam logic [4:0] S_EXPB  = 5'd17;
  localparam logic [4:0] S_EXPC  = 5'd18;
  localparam logic [4:0] S_ROOT  = 5'd19;
  localparam logic [4:0] S_GAIN  = 5'd20;
  localparam logic [4:0] S_SCALE = 5'd21;
  localparam logic [4:0] S_OUT   = 5'd22;

  logic [4:0] state;
  logic [4:0] state_next;
  logic [5:0] step;
  logic [5:0] step_next;
  logic [4:0] op;

  // Sequencer: next state and operation for the datapath.
  always_comb begin
    state_next = state;
    op         = OP_NONE;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          op         = OP_LOAD;
          state_next = S_DISP;
        end
      end
      S_DISP: begin
        unique case (stat.action)
          ACT_SAMPLE: begin
            op         = OP_READ;
            state_next = S_FETCH;
          end
          ACT_SETPAR: begin
            op         = OP_SETPAR;
            state_next = S_IDLE;
          end
          ACT_CLRENV: begin
            op         = OP_CLRENV;
            state_next = S_IDLE;
          end
          default: state_next = S_IDLE;
        endcase
      end
      S_FETCH: begin
        op         = OP_FETCH;
        state_next = S_ENVA;
      end
      S_ENVA: begin
        op         = OP_ENV_A;
        state_next = S_ENVB;
      end
      S_ENVB: begin
        op         = OP_ENV_B;
        state_next = S_ENVW;
      end
      S_ENVW: begin
        op         = OP_ENV_W;
        state_next = S_NORM;
      end
      S_NORM: begin
        op = OP_NORM;
        if (stat.norm_done) begin
          state_next = S_SQR;
        end
      end
      S_SQR: begin
        op = OP_SQR;
        if (step == 6'(SQR_STEPS - 1)) begin
          state_next = S_DBA;
        end
      end
      S_DBA: begin
        op         = OP_DB_A;
        state_next = S_DBB;
      end
      S_DBB: begin
        op         = OP_DB_B;
        state_next = S_LVL;
      end
      S_LVL: begin
        op         = OP_LVL;
        state_next = S_CVA;
      end
      S_CVA: begin
        op         = OP_CV_A;
        state_next = S_CVB;
      end
      S_CVB: begin
        op         = OP_CV_B;
        state_next = S_CVC;
      end
      S_CVC: begin
        op         = OP_CV_C;
        state_next = S_CVD;
      end
      S_CVD: begin
        op         = OP_CV_D;
        state_next = S_DIV;
      end
      S_DIV: begin
        op = OP_DIV;
        if (step == 6'(DIV_STEPS - 1)) begin
          state_next = S_EXPA;
        end
      end
      S_EXPA: begin
        op         = OP_EXP_A;
        state_next = S_EXPB;
      end
      S_EXPB: begin
        op         = OP_EXP_B;
        state_next = S_EXPC;
      end
      S_EXPC: begin
        op         = OP_EXP_C;
        state_next = S_ROOT;
      end
      S_ROOT: begin
        op = OP_ROOT;
        if (step == 6'(ROOT_STEPS - 1)) begin
          state_next = S_GAIN;
        end
      end
      S_GAIN: begin
        op         = OP_GAIN;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        op         = OP_SCALE;
        state_next = S_OUT;
      end
      S_OUT: begin
        // Wait until the output register is free.
        if (!out_valid || out_ready) begin
          op         = OP_OUT;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Step counter restarts on every state change.
  assign step_next = (state_next != state) ? 6'd0 : step + 6'd1;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      step      <= 6'd0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      step  <= step_next;
      if (op == OP_OUT) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign in_ready = (state == S_IDLE);
  assign cmd.op   = op;
  assign cmd.step = step;

  `CHK_NEXT(a_busy_after_accept, clk, rst, in_valid && in_ready, !in_ready)
  `CHK_NOW(a_out_reg_free, clk, rst, op == OP_OUT, !out_valid || out_ready)
  `CHK_NOW(a_short_loop_bound, clk, rst, state == S_SQR || state == S_ROOT, step[5:4] == 2'b00)

endmodule

@@ src/soft_knee_channel_compressor_top.sv @@
// Channel   Direction  Beat contents
// s_axis    in         tuser: action; tdata: channel, sample, threshold, ratio
// m_axis    out        tdata: sample_out, gain_applied, reduction_level
// cfg       in         cfg_index selects the register, cfg_data is the value
//
// A sample beat runs through the sequencer steps from acceptance to the
// output register, among them the 46-step restoring divider, the 16 log
// squarings and the 16 root multiplies. Threshold and clear beats are latched
// when idle and written on dispatch. Reset is synchronous and clears all
// channel state through valid bits, so no clearing pass is needed. A result
// waiting on m_axis does not stop the next beat from being accepted.
module soft_knee_channel_compressor_top import skcc_pkg::*; #(
  parameter int CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [3:0] channel, [19:4] sample_in, [35:20] threshold_level,
  // [50:36] ratio_value, [55:51] zero
  input  logic [55:0] s_axis_tdata,
  // [1:0] action
  input  logic [1:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [15:0] sample_out, [32:16] gain_applied, [47:33] reduction_level
  output logic [47:0] m_axis_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_data
);

  cmd_t        cmd;
  stat_t       stat;
  logic [15:0] out_sample;
  logic [16:0] out_gain;
  logic [14:0] out_reduction;

  assign cfg_ready = 1'b1;

  skcc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  skcc_datapath #(.CHANNELS(CHANNELS)) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_valid),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_action     (s_axis_tuser),
    .in_channel    (s_axis_tdata[3:0]),
    .in_sample     (s_axis_tdata[19:4]),
    .in_threshold  (s_axis_tdata[35:20]),
    .in_ratio      (s_axis_tdata[50:36]),
    .cmd           (cmd),
    .stat          (stat),
    .out_sample    (out_sample),
    .out_gain      (out_gain),
    .out_reduction (out_reduction)
  );

  assign m_axis_tdata = {out_reduction, out_gain, out_sample};

endmodule
